FILE: rtl/core/tfd_pkg.sv
// Shared types and constants of the TLV frame deframer.
package tfd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 1024;
  localparam int unsigned MIN_FRAME     = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_MAGIC       = 3'd2,
    ST_VERSION     = 3'd3,
    ST_HDR_OVERRUN = 3'd4,
    ST_TLV_OVERRUN = 3'd5,
    ST_CRC         = 3'd6,
    ST_TOO_LONG    = 3'd7
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic        in_header;
    logic [7:0]  tlv_id;
    logic [7:0]  value_type;
    logic [7:0]  value_len;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    logic        value_last;
    logic [7:0]  message_type;
    status_e     status;
  } rec_t;

endpackage

FILE: rtl/core/tfd_in_if.sv
// Input byte channel of the deframer.
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

FILE: rtl/core/tfd_out_if.sv
// Output record channel of the deframer.
interface tfd_out_if import tfd_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_e      kind;
  logic       in_header;
  logic [7:0] tlv_id;
  logic [7:0] value_type;
  logic [7:0] value_len;
  logic [7:0] byte_index;
  logic [7:0] data_byte;
  logic       value_last;
  logic [7:0] message_type;
  status_e    status;

  modport source (output valid, output kind, output in_header, output tlv_id,
                  output value_type, output value_len, output byte_index,
                  output data_byte, output value_last, output message_type,
                  output status, input ready);
  modport sink   (input valid, input kind, input in_header, input tlv_id,
                  input value_type, input value_len, input byte_index,
                  input data_byte, input value_last, input message_type,
                  input status, output ready);
endinterface

FILE: rtl/core/tfd_crc16.sv
// One-byte update of the reflected CRC-16 used by the frame check.
module tfd_crc16 import tfd_pkg::*; (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

FILE: rtl/core/tfd_parser.sv
// Frame state, byte hold, TLV parser and status evaluation for one beat.
module tfd_parser import tfd_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic [7:0] magic_i,
  input  logic [7:0] version_i,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 2);

  typedef enum logic [5:0] {
    PH_MAGIC   = 6'b000001,
    PH_VERSION = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_HLEN    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_e;

  localparam logic [1:0] FP_ID    = 2'd0;
  localparam logic [1:0] FP_TYPE  = 2'd1;
  localparam logic [1:0] FP_LEN   = 2'd2;
  localparam logic [1:0] FP_VALUE = 2'd3;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d, crc_nxt;
  logic [15:0]     hold_q, hold_d;
  logic [1:0]      fill_q, fill_d;
  logic [7:0]      hl_q, hl_d;
  logic [7:0]      msg_q, msg_d;
  logic [1:0]      fpos_q, fpos_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      vpos_q, vpos_d;
  status_e         err_q, err_d;

  tfd_crc16 u_crc (
    .crc_i  (crc_q),
    .data_i (hold_q[15:8]),
    .crc_o  (crc_nxt)
  );

  always_comb begin
    logic        over;
    logic [7:0]  rb;
    logic        hdr;
    logic [7:0]  hl_dec;
    logic [8:0]  vpos_inc;
    logic [15:0] got;
    logic        have;
    rec_t        r;
    status_e     st;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    hl_d    = hl_q;
    msg_d   = msg_q;
    fpos_d  = fpos_q;
    id_d    = id_q;
    type_d  = type_q;
    len_d   = len_q;
    vpos_d  = vpos_q;
    err_d   = err_q;
    have    = 1'b0;
    r       = '0;
    st      = ST_OK;
    rb      = hold_q[15:8];
    hdr     = (hl_q != 8'd0);
    hl_dec  = hdr ? hl_q - 8'd1 : hl_q;
    vpos_inc = {1'b0, vpos_q} + 9'd1;

    if (cnt_q < CntW'(MaxFrame + 1)) begin
      cnt_d = cnt_q + CntW'(1);
    end
    over = (cnt_d > CntW'(MaxFrame));
    if (over) begin
      phase_d = PH_SKIP;
    end

    if (fill_q == 2'd2) begin
      crc_d = crc_nxt;
      case (phase_d)
        PH_MAGIC: begin
          if (rb != magic_i) begin
            err_d   = ST_MAGIC;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (rb != version_i) begin
            err_d   = ST_VERSION;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          msg_d   = rb;
          phase_d = PH_HLEN;
        end
        PH_HLEN: begin
          hl_d    = rb;
          fpos_d  = FP_ID;
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          hl_d = hl_dec;
          case (fpos_q)
            FP_ID: begin
              id_d   = rb;
              fpos_d = FP_TYPE;
            end
            FP_TYPE: begin
              type_d = rb;
              fpos_d = FP_LEN;
            end
            FP_LEN: begin
              len_d  = rb;
              vpos_d = 8'd0;
              if (hdr && (rb > hl_dec)) begin
                err_d   = ST_TLV_OVERRUN;
                phase_d = PH_SKIP;
                fpos_d  = FP_ID;
              end else begin
                have         = 1'b1;
                r.kind       = KIND_START;
                r.in_header  = hdr;
                r.tlv_id     = id_q;
                r.value_type = type_q;
                r.value_len  = rb;
                r.value_last = (rb == 8'd0);
                fpos_d       = (rb == 8'd0) ? FP_ID : FP_VALUE;
              end
            end
            default: begin
              have         = 1'b1;
              r.kind       = KIND_VALUE;
              r.in_header  = hdr;
              r.tlv_id     = id_q;
              r.value_type = type_q;
              r.value_len  = len_q;
              r.byte_index = vpos_q;
              r.data_byte  = rb;
              r.value_last = (vpos_inc >= {1'b0, len_q});
              vpos_d       = vpos_inc[7:0];
              if (vpos_inc >= {1'b0, len_q}) begin
                fpos_d = FP_ID;
              end
            end
          endcase
          if (hdr && (hl_dec == 8'd0)) begin
            fpos_d = FP_ID;
          end
        end
        default: begin
          hl_d = hl_dec;
        end
      endcase
    end

    hold_d = {hold_q[7:0], byte_i};
    fill_d = (fill_q == 2'd2) ? 2'd2 : fill_q + 2'd1;

    got = {byte_i, hold_q[7:0]};
    if (over) begin
      st = ST_TOO_LONG;
    end else if (cnt_d < CntW'(MIN_FRAME)) begin
      st = ST_SHORT;
    end else if ((err_d == ST_MAGIC) || (err_d == ST_VERSION)) begin
      st = err_d;
    end else if (hl_d != 8'd0) begin
      st = ST_HDR_OVERRUN;
    end else if (crc_d != got) begin
      st = ST_CRC;
    end else if ((err_d == ST_TLV_OVERRUN) ||
                 ((phase_d == PH_PAYLOAD) && (fpos_d == FP_VALUE))) begin
      st = ST_TLV_OVERRUN;
    end

    r.message_type = msg_d;
    if (last_i) begin
      r.kind   = KIND_STATUS;
      r.status = st;
    end
    rec_valid_o = last_i || have;
    rec_o       = r;

    if (last_i) begin
      phase_d = PH_MAGIC;
      cnt_d   = '0;
      crc_d   = CRC_INIT;
      hold_d  = 16'h0000;
      fill_d  = 2'd0;
      hl_d    = 8'd0;
      msg_d   = 8'd0;
      fpos_d  = FP_ID;
      id_d    = 8'd0;
      type_d  = 8'd0;
      len_d   = 8'd0;
      vpos_d  = 8'd0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      hold_q  <= 16'h0000;
      fill_q  <= 2'd0;
      hl_q    <= 8'd0;
      msg_q   <= 8'd0;
      fpos_q  <= FP_ID;
      id_q    <= 8'd0;
      type_q  <= 8'd0;
      len_q   <= 8'd0;
      vpos_q  <= 8'd0;
      err_q   <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      hold_q  <= hold_d;
      fill_q  <= fill_d;
      hl_q    <= hl_d;
      msg_q   <= msg_d;
      fpos_q  <= fpos_d;
      id_q    <= id_d;
      type_q  <= type_d;
      len_q   <= len_d;
      vpos_q  <= vpos_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: rtl/core/tlv_frame_deframer_crc16_top.sv
// Top level of the TLV frame deframer with CRC-16 check.
// A beat is held in the input register; any record it yields goes to the
// record register. Throughput: one input beat per cycle while the output
// is not stalled; the parser and byte-wide CRC update sit between the two.
// Reset: asynchronous, active low; clears frame state, the CRC to all ones,
// the pipeline valids and both configuration registers to zero.
module tlv_frame_deframer_crc16_top import tfd_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tfd_in_if.sink                in_i,
  tfd_out_if.source             out_o
);

  logic [7:0] magic_q, version_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q, out_valid_d;
  rec_t       out_rec_q;
  logic       out_free, advance, in_fire;
  logic       rec_valid;
  rec_t       rec;

  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= 8'h00;
      version_q <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC:   magic_q   <= cfg_data_i;
        CFG_VERSION: version_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.frame_last;
    end
  end

  tfd_parser #(
    .MaxFrame (MaxFrame)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (s1_byte_q),
    .last_i      (s1_last_q),
    .magic_i     (magic_q),
    .version_i   (version_q),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = rec_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rec_valid) begin
      out_rec_q <= rec;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_rec_q.kind;
  assign out_o.in_header    = out_rec_q.in_header;
  assign out_o.tlv_id       = out_rec_q.tlv_id;
  assign out_o.value_type   = out_rec_q.value_type;
  assign out_o.value_len    = out_rec_q.value_len;
  assign out_o.byte_index   = out_rec_q.byte_index;
  assign out_o.data_byte    = out_rec_q.data_byte;
  assign out_o.value_last   = out_rec_q.value_last;
  assign out_o.message_type = out_rec_q.message_type;
  assign out_o.status       = out_rec_q.status;

endmodule
